// ===== design/atlas_first_fit_rect_placer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the atlas rectangle placer
// Clocked property wrappers with reset disable, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ATLAS_FIRST_FIT_RECT_PLACER_ASSERT_SVH
`define ATLAS_FIRST_FIT_RECT_PLACER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define AFFRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante
`define AFFRP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/affrp_pkg.sv =====
// ----------------------------------------------------------------------------
// affrp_pkg
// Shared widths, codes and defaults of the atlas first-fit rectangle placer.
// ----------------------------------------------------------------------------
package affrp_pkg;

  // Field widths
  localparam int unsigned RECT_W     = 8;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned MARGIN_W   = 4;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  // Padded size: 255 + 2 * 15 fits 9 bits
  localparam int unsigned DIM_W      = 9;
  // Free-run counters saturate above any padded height
  localparam int unsigned CNT_W      = 9;

  // Search chunk of the first-fit scan
  localparam int unsigned CHUNK      = 8;
  localparam int unsigned CHUNK_LG   = 3;

  // Default parameter values
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_ATLAS_DIM = 9'd256;
  localparam logic [MARGIN_W-1:0]   RST_MARGIN    = 4'd3;

  // Request codes
  localparam logic FUNC_CLEAR = 1'b0;
  localparam logic FUNC_PLACE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_MARGIN   = 2'd2;

endpackage

// ===== design/affrp_shift.sv =====
// ----------------------------------------------------------------------------
// affrp_shift
// Shared barrel shifter of the placer: logical left or right shift of one
// row-wide vector by a variable amount, zeros shifted in.
// ----------------------------------------------------------------------------
module affrp_shift #(
  parameter int unsigned WIDTH = 256,
  parameter int unsigned AMW   = 10
) (
  input  logic [WIDTH-1:0] opnd_i,
  input  logic [AMW-1:0]   amt_i,
  input  logic             left_i,
  output logic [WIDTH-1:0] res_o
);

  // Shift by the full amount; amounts past the width give zero
  always_comb begin
    if (left_i) begin
      res_o = opnd_i << amt_i;
    end else begin
      res_o = opnd_i >> amt_i;
    end
  end

endmodule

// ===== design/atlas_first_fit_rect_placer.sv =====
// ----------------------------------------------------------------------------
// atlas_first_fit_rect_placer
// First-fit rectangle placer over an occupancy bitmap of atlas cells.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A clear item sweeps the occupancy memory
// one row per cycle, and the same sweep runs once after reset before the first
// item is taken. A place item walks the atlas rows one per memory read: each
// row is read and folded into per-column free-run counters, and each row that
// closes a candidate window then passes through doubling steps on the shared
// shifter that finds horizontal free runs. The hit row then goes through the
// chunked first-fit search and a read-modify-write of each marked row of the
// rectangle. A request whose padded size does not fit the atlas goes to the
// response without reading the memory. The single memory port and the shared
// shifter serialize this work. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module atlas_first_fit_rect_placer import affrp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [RECT_W-1:0]     rect_width_i,
  input  logic [RECT_W-1:0]     rect_height_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  placed_o,
  output logic [POS_W-1:0]      pos_x_o,
  output logic [POS_W-1:0]      pos_y_o,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned MX   = (WW > HW) ? WW : HW;
  localparam int unsigned CMPW = (MX > 10) ? MX : 10;
  localparam int unsigned RAW  = $clog2(MAX_HEIGHT);
  localparam int unsigned NCH  = (MAX_WIDTH + CHUNK - 1) / CHUNK;
  localparam int unsigned KW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PADW = NCH * CHUNK;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_UPD,
    ST_SMEAR,
    ST_CHECK,
    ST_SCAN,
    ST_MASK1,
    ST_MASK2,
    ST_MREAD,
    ST_MWRITE,
    ST_RESP
  } state_e;

  state_e                state_q, state_d;

  logic [CFG_DATA_W-1:0] atlas_width_q, atlas_height_q;
  logic [MARGIN_W-1:0]   pad_margin_q;

  logic [RECT_W-1:0]     rw_q, rw_d, rh_q, rh_d;
  logic [DIM_W-1:0]      mw_q, mw_d, mh_q, mh_d;
  logic [CMPW-1:0]       w_q, w_d, h_q, h_d;
  logic [CMPW-1:0]       r_q, r_d, mr_q, mr_d, l_q, l_d;
  logic [CMPW-1:0]       x_q, x_d, y_q, y_d;
  logic [KW-1:0]         k_q, k_d;
  logic [RAW-1:0]        clr_q, clr_d;
  logic                  clr_rsp_q, clr_rsp_d;
  logic                  res_placed_q, res_placed_d;
  logic [MAX_WIDTH-1:0]  lim_mask_q, lim_mask_d;
  logic [MAX_WIDTH-1:0]  win_q, win_d;
  logic [MAX_WIDTH-1:0]  mark_q, mark_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_placed_q, out_placed_d;
  logic [POS_W-1:0]      out_x_q, out_x_d, out_y_q, out_y_d;

  // Occupancy memory, one row per word
  logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0]  rd_q;
  logic                  mem_we, mem_re;
  logic [RAW-1:0]        mem_addr;
  logic [MAX_WIDTH-1:0]  mem_wdata;

  // Per-column count of free rows ending at the current row
  logic [CNT_W-1:0]      cnt_q [MAX_WIDTH];
  logic [CNT_W-1:0]      cnt_n [MAX_WIDTH];
  logic                  cnt_clr, cnt_upd;
  logic [MAX_WIDTH-1:0]  vmask;

  // Shared shifter
  logic [MAX_WIDTH-1:0]  sh_opnd, sh_res;
  logic [CMPW-1:0]       sh_amt;
  logic                  sh_left;
  logic                  dbl;

  // Request decode at accept time
  logic                  in_acc;
  logic [CMPW-1:0]       w_in, h_in;
  logic [DIM_W-1:0]      mw_in, mh_in, m2;

  // First-fit search
  logic [PADW-1:0]       xpad;
  logic [CHUNK-1:0]      chunk;
  logic [CHUNK_LG-1:0]   bi;
  logic [CMPW-1:0]       jpos;
  logic                  out_ld;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_ld      = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  assign out_valid_o = out_valid_q;
  assign placed_o    = out_placed_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;

  // Clamp atlas size and form the padded rectangle size
  assign w_in  = (CMPW'(atlas_width_q) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH)
                                                           : CMPW'(atlas_width_q);
  assign h_in  = (CMPW'(atlas_height_q) > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT)
                                                             : CMPW'(atlas_height_q);
  assign m2    = DIM_W'({pad_margin_q, 1'b0});
  assign mw_in = DIM_W'(rect_width_i) + m2;
  assign mh_in = DIM_W'(rect_height_i) + m2;

  // Fold the row just read into the free-run counters
  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      if (rd_q[c]) begin
        cnt_n[c] = '0;
      end else if (cnt_q[c] == {CNT_W{1'b1}}) begin
        cnt_n[c] = cnt_q[c];
      end else begin
        cnt_n[c] = cnt_q[c] + CNT_W'(1);
      end
      vmask[c] = (cnt_n[c] >= CNT_W'(mh_q));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      if (cnt_clr) begin
        cnt_q[c] <= '0;
      end else if (cnt_upd) begin
        cnt_q[c] <= cnt_n[c];
      end
    end
  end

  // Doubling step while twice the run still fits the padded width
  assign dbl = ({1'b0, l_q} << 1) <= (CMPW + 1)'(mw_q);

  // Select the shifter operand for the current step
  always_comb begin
    case (state_q)
      ST_PREP: begin
        sh_opnd = '1;
        sh_amt  = w_q - CMPW'(mw_q);
        sh_left = 1'b1;
      end
      ST_SMEAR: begin
        sh_opnd = win_q;
        sh_amt  = dbl ? l_q : (CMPW'(mw_q) - l_q);
        sh_left = 1'b0;
      end
      ST_MASK1: begin
        sh_opnd = '1;
        sh_amt  = CMPW'(rw_q);
        sh_left = 1'b1;
      end
      ST_MASK2: begin
        sh_opnd = mark_q;
        sh_amt  = x_q;
        sh_left = 1'b1;
      end
      default: begin
        sh_opnd = win_q;
        sh_amt  = '0;
        sh_left = 1'b0;
      end
    endcase
  end

  affrp_shift #(
    .WIDTH (MAX_WIDTH),
    .AMW   (CMPW)
  ) u_shift (
    .opnd_i (sh_opnd),
    .amt_i  (sh_amt),
    .left_i (sh_left),
    .res_o  (sh_res)
  );

  // Pick the current chunk and its lowest free origin
  always_comb begin
    xpad                  = '0;
    xpad[MAX_WIDTH-1:0]   = win_q;
    chunk                 = xpad[k_q*CHUNK +: CHUNK];
    bi                    = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        bi = CHUNK_LG'(i);
      end
    end
    jpos = CMPW'({k_q, bi});
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    rw_d         = rw_q;
    rh_d         = rh_q;
    mw_d         = mw_q;
    mh_d         = mh_q;
    w_d          = w_q;
    h_d          = h_q;
    r_d          = r_q;
    mr_d         = mr_q;
    l_d          = l_q;
    x_d          = x_q;
    y_d          = y_q;
    k_d          = k_q;
    clr_d        = clr_q;
    clr_rsp_d    = clr_rsp_q;
    res_placed_d = res_placed_q;
    lim_mask_d   = lim_mask_q;
    win_d        = win_q;
    mark_d       = mark_q;
    cnt_clr      = 1'b0;
    cnt_upd      = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = r_q[RAW-1:0];
    mem_wdata    = '0;

    case (state_q)
      ST_CLEAR: begin
        // Sweep zeros through the memory
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + RAW'(1);
        if (clr_q == RAW'(MAX_HEIGHT - 1)) begin
          state_d = clr_rsp_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_placed_d = 1'b0;
          x_d          = '0;
          y_d          = '0;
          rw_d         = rect_width_i;
          rh_d         = rect_height_i;
          mw_d         = mw_in;
          mh_d         = mh_in;
          w_d          = w_in;
          h_d          = h_in;
          r_d          = '0;
          cnt_clr      = 1'b1;
          if (func_i == FUNC_CLEAR) begin
            clr_d     = '0;
            clr_rsp_d = 1'b1;
            state_d   = ST_CLEAR;
          end else if (h_in <= CMPW'(mh_in) || w_in <= CMPW'(mw_in)) begin
            state_d = ST_RESP;
          end else if (mw_in == '0 || mh_in == '0) begin
            // Empty window: the first origin always fits
            res_placed_d = 1'b1;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        // Keep only origins left of the last column that fits
        lim_mask_d = ~sh_res;
        state_d    = ST_READ;
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        cnt_upd = 1'b1;
        if (r_q + CMPW'(1) < CMPW'(mh_q)) begin
          r_d     = r_q + CMPW'(1);
          state_d = ST_READ;
        end else begin
          win_d   = vmask;
          l_d     = CMPW'(1);
          state_d = ST_SMEAR;
        end
      end
      ST_SMEAR: begin
        // Widen free runs: double, then one overlapping step to the exact width
        if (dbl) begin
          win_d = win_q & sh_res;
          l_d   = {l_q[CMPW-2:0], 1'b0};
        end else begin
          win_d   = win_q & sh_res & lim_mask_q;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (|win_q) begin
          k_d     = '0;
          state_d = ST_SCAN;
        end else if (r_q == h_q - CMPW'(2)) begin
          state_d = ST_RESP;
        end else begin
          r_d     = r_q + CMPW'(1);
          state_d = ST_READ;
        end
      end
      ST_SCAN: begin
        if (|chunk) begin
          res_placed_d = 1'b1;
          x_d          = jpos + CMPW'(pad_margin_q);
          y_d          = r_q + CMPW'(1) - CMPW'(mh_q) + CMPW'(pad_margin_q);
          if (rw_q == '0 || rh_q == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_MASK1;
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_MASK1: begin
        mark_d  = ~sh_res;
        state_d = ST_MASK2;
      end
      ST_MASK2: begin
        mark_d  = sh_res;
        mr_d    = y_q;
        state_d = ST_MREAD;
      end
      ST_MREAD: begin
        mem_re   = 1'b1;
        mem_addr = mr_q[RAW-1:0];
        state_d  = ST_MWRITE;
      end
      ST_MWRITE: begin
        // Merge the rectangle into the row just read
        mem_we    = 1'b1;
        mem_addr  = mr_q[RAW-1:0];
        mem_wdata = rd_q | mark_q;
        if (mr_q == y_q + CMPW'(rh_q) - CMPW'(1)) begin
          state_d = ST_RESP;
        end else begin
          mr_d    = mr_q + CMPW'(1);
          state_d = ST_MREAD;
        end
      end
      ST_RESP: begin
        if (out_ld) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register: load on completion, drop once taken
  always_comb begin
    out_valid_d  = out_valid_q;
    out_placed_d = out_placed_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    if (out_ld) begin
      out_valid_d  = 1'b1;
      out_placed_d = res_placed_q;
      out_x_d      = x_q[POS_W-1:0];
      out_y_d      = y_q[POS_W-1:0];
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      atlas_width_q  <= RST_ATLAS_DIM;
      atlas_height_q <= RST_ATLAS_DIM;
      pad_margin_q   <= RST_MARGIN;
      rw_q           <= '0;
      rh_q           <= '0;
      mw_q           <= '0;
      mh_q           <= '0;
      w_q            <= '0;
      h_q            <= '0;
      r_q            <= '0;
      mr_q           <= '0;
      l_q            <= '0;
      x_q            <= '0;
      y_q            <= '0;
      k_q            <= '0;
      clr_q          <= '0;
      clr_rsp_q      <= 1'b0;
      res_placed_q   <= 1'b0;
      lim_mask_q     <= '0;
      win_q          <= '0;
      mark_q         <= '0;
      out_valid_q    <= 1'b0;
      out_placed_q   <= 1'b0;
      out_x_q        <= '0;
      out_y_q        <= '0;
    end else begin
      state_q      <= state_d;
      rw_q         <= rw_d;
      rh_q         <= rh_d;
      mw_q         <= mw_d;
      mh_q         <= mh_d;
      w_q          <= w_d;
      h_q          <= h_d;
      r_q          <= r_d;
      mr_q         <= mr_d;
      l_q          <= l_d;
      x_q          <= x_d;
      y_q          <= y_d;
      k_q          <= k_d;
      clr_q        <= clr_d;
      clr_rsp_q    <= clr_rsp_d;
      res_placed_q <= res_placed_d;
      lim_mask_q   <= lim_mask_d;
      win_q        <= win_d;
      mark_q       <= mark_d;
      out_valid_q  <= out_valid_d;
      out_placed_q <= out_placed_d;
      out_x_q      <= out_x_d;
      out_y_q      <= out_y_d;
      // Configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data_i;
          CFG_ATLAS_HEIGHT: atlas_height_q <= cfg_data_i;
          CFG_PAD_MARGIN:   pad_margin_q   <= cfg_data_i[MARGIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Occupancy memory port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

`include "atlas_first_fit_rect_placer_assert.svh"

  `AFFRP_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "placer ready right after taking an item")
  `AFFRP_ASSERT_IMP(a_scan_has_hit, clk_i, rst_ni, state_q == ST_SCAN, |win_q, "first-fit scan entered with no free origin")
  `AFFRP_ASSERT_IMP(a_fail_zero_pos, clk_i, rst_ni, out_valid_o && !placed_o, pos_x_o == '0 && pos_y_o == '0, "unplaced result carries a position")

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the atlas first-fit rectangle placer. A directed
// table covers size extremes, clears and padded sizes that just miss the
// atlas. Random placements and clears then run over a series of atlas and
// margin settings. An occupancy-map model predicts every placement that the
// directed table does not give itself.
module testbench;
  import affrp_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = DEF_MAX_HEIGHT + 16;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic             placed;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } placement_t;

  typedef struct packed {
    logic              func;
    logic [RECT_W-1:0] rect_w;
    logic [RECT_W-1:0] rect_h;
    logic              typed;
    placement_t        want;
  } directed_row_t;

  localparam placement_t NO_FIT = '0;
  localparam placement_t CORNER = '{1'b1, 8'd3, 8'd3};

  // Directed rows, run under the reset setting (256 x 256, margin 3)
  directed_row_t directed_rows [16] = '{
    '{FUNC_PLACE, 8'd0,   8'd0,   1'b1, CORNER},  // zero-sized, margin window only
    '{FUNC_PLACE, 8'd10,  8'd4,   1'b1, CORNER},
    '{FUNC_PLACE, 8'd255, 8'd255, 1'b1, NO_FIT},  // padded size beyond the atlas
    '{FUNC_PLACE, 8'd250, 8'd1,   1'b1, NO_FIT},  // padded width equals the atlas
    '{FUNC_PLACE, 8'd249, 8'd1,   1'b0, NO_FIT},
    '{FUNC_PLACE, 8'd1,   8'd249, 1'b0, NO_FIT},
    '{FUNC_PLACE, 8'd128, 8'd128, 1'b0, NO_FIT},
    '{FUNC_PLACE, 8'd0,   8'd0,   1'b0, NO_FIT},
    '{FUNC_CLEAR, 8'd255, 8'd255, 1'b1, NO_FIT},
    '{FUNC_PLACE, 8'd249, 8'd249, 1'b1, CORNER},  // largest padded fit
    '{FUNC_PLACE, 8'd1,   8'd1,   1'b0, NO_FIT},
    '{FUNC_CLEAR, 8'd0,   8'd0,   1'b1, NO_FIT},
    '{FUNC_PLACE, 8'd0,   8'd255, 1'b1, NO_FIT},
    '{FUNC_PLACE, 8'd255, 8'd0,   1'b1, NO_FIT},
    '{FUNC_PLACE, 8'd127, 8'd200, 1'b1, CORNER},
    '{FUNC_PLACE, 8'd128, 8'd63,  1'b0, NO_FIT}
  };

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_func   = FUNC_CLEAR;
  logic [RECT_W-1:0]     in_rect_w = '0;
  logic [RECT_W-1:0]     in_rect_h = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ATLAS_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  placed;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic                  cfg_ready;

  // Occupancy model and its register copies
  bit                    occ_map  [DEF_MAX_HEIGHT][DEF_MAX_WIDTH];
  int                    area_sum [DEF_MAX_HEIGHT+1][DEF_MAX_WIDTH+1];
  logic [CFG_DATA_W-1:0] atlas_w_q = RST_ATLAS_DIM;
  logic [CFG_DATA_W-1:0] atlas_h_q = RST_ATLAS_DIM;
  logic [MARGIN_W-1:0]   margin_q  = RST_MARGIN;

  placement_t placement_q [$];
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  int         tx_idle_pct    = 20;
  int         rx_idle_pct    = 78;
  bit         hold_off_go    = 1'b0;

  atlas_first_fit_rect_placer i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (in_func),
    .rect_width_i  (in_rect_w),
    .rect_height_i (in_rect_h),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .placed_o      (placed),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Empty the whole map, cells outside the used area included
  function automatic void wipe_map();
    foreach (occ_map[r, c]) occ_map[r][c] = 1'b0;
  endfunction

  // First-fit search over padded origins, then mark the bare rectangle
  function automatic placement_t place_rect(input logic [RECT_W-1:0] rw,
                                            input logic [RECT_W-1:0] rh);
    placement_t res;
    int w, h, m, mw, mh, s, r, c, i, j;
    res = '0;
    w  = (atlas_w_q > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(atlas_w_q);
    h  = (atlas_h_q > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(atlas_h_q);
    m  = int'(margin_q);
    mw = int'(rw) + 2 * m;
    mh = int'(rh) + 2 * m;
    if (h <= mh || w <= mw) return res;
    // Build the summed-area table of occupied cells
    for (c = 0; c <= w; c++) area_sum[0][c] = 0;
    for (r = 0; r < h; r++) begin
      area_sum[r+1][0] = 0;
      for (c = 0; c < w; c++) begin
        area_sum[r+1][c+1] = int'(occ_map[r][c]) + area_sum[r][c+1]
                             + area_sum[r+1][c] - area_sum[r][c];
      end
    end
    // Scan origins row by row and take the first free window
    for (i = 0; i < h - mh; i++) begin
      for (j = 0; j < w - mw; j++) begin
        s = area_sum[i+mh][j+mw] - area_sum[i][j+mw]
            - area_sum[i+mh][j] + area_sum[i][j];
        if (s == 0) begin
          for (r = 0; r < int'(rh); r++) begin
            for (c = 0; c < int'(rw); c++) occ_map[i+m+r][j+m+c] = 1'b1;
          end
          res.placed = 1'b1;
          res.pos_x  = POS_W'(j + m);
          res.pos_y  = POS_W'(i + m);
          return res;
        end
      end
    end
    return res;
  endfunction

  // Offer one item, hold it until taken, then record what it should return
  task automatic send_item(input logic fn, input logic [RECT_W-1:0] rw,
                           input logic [RECT_W-1:0] rh, input logic typed,
                           input placement_t want);
    placement_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= fn;
    in_rect_w <= rw;
    in_rect_h <= rh;
    do @(posedge clk); while (in_stall);
    if (fn == FUNC_CLEAR) begin
      wipe_map();
      got = NO_FIT;
    end else begin
      got = place_rect(rw, rh);
    end
    if (typed) got = want;
    placement_q.insert(placement_q.size(), got);
  endtask

  // Stop offering and wait until every expected result has come
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
  endtask

  // Write one register and mirror it in the model
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATLAS_WIDTH:  atlas_w_q = data;
      CFG_ATLAS_HEIGHT: atlas_h_q = data;
      CFG_PAD_MARGIN:   margin_q  = data[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  // Retune the atlas once the block has gone quiet
  task automatic set_atlas(input logic [CFG_DATA_W-1:0] w,
                           input logic [CFG_DATA_W-1:0] h,
                           input logic [MARGIN_W-1:0] m);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_ATLAS_WIDTH, w);
    write_reg(CFG_ATLAS_HEIGHT, h);
    write_reg(CFG_PAD_MARGIN, CFG_DATA_W'(m));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Random placements sized to the atlas, with clears and stray sizes mixed in
  task automatic run_phase(input int n);
    int k, sel, eff_w, eff_h, span_w, span_h;
    logic fn;
    logic [RECT_W-1:0] rw, rh;
    eff_w  = (atlas_w_q > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(atlas_w_q);
    eff_h  = (atlas_h_q > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(atlas_h_q);
    span_w = (eff_w - 2 * int'(margin_q)) / 3;
    span_h = (eff_h - 2 * int'(margin_q)) / 3;
    if (span_w < 1) span_w = 1;
    if (span_h < 1) span_h = 1;
    if (span_w > 255) span_w = 255;
    if (span_h > 255) span_h = 255;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      fn  = FUNC_PLACE;
      if (sel < 14) begin
        rw = RECT_W'($urandom_range(255));
        rh = RECT_W'($urandom_range(255));
        if (sel < 4) fn = FUNC_CLEAR;
      end else begin
        rw = RECT_W'($urandom_range(span_w));
        rh = RECT_W'($urandom_range(span_h));
      end
      send_item(fn, rw, rh, 1'b0, NO_FIT);
    end
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (placement_q.size() == 0) begin
        $display("%0t: result with no item outstanding: placed=%0d x=%0d y=%0d",
                 $time, placed, pos_x, pos_y);
        mismatch_count++;
      end else begin
        want = placement_q.pop_front();
        if (placed !== want.placed) begin
          $display("%0t: placed expected %0d actual %0d", $time, want.placed, placed);
          mismatch_count++;
        end
        if (pos_x !== want.pos_x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, pos_x);
          mismatch_count++;
        end
        if (pos_y !== want.pos_y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, pos_y);
          mismatch_count++;
        end
      end
    end
  end

  // Count cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Main sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles lightly, receiver heavily
    tx_idle_pct = 20;
    rx_idle_pct = 78;
    foreach (directed_rows[n]) begin
      send_item(directed_rows[n].func, directed_rows[n].rect_w, directed_rows[n].rect_h,
                directed_rows[n].typed, directed_rows[n].want);
    end
    set_atlas(9'd32, 9'd24, 4'd3);
    run_phase(70);
    set_atlas(9'd1, 9'd1, 4'd0);
    run_phase(12);
    set_atlas(9'd511, 9'd300, 4'd0);
    run_phase(16);

    // Roles swapped; shrink without a clear so stale cells stay outside
    tx_idle_pct = 78;
    rx_idle_pct = 20;
    set_atlas(9'd64, 9'd48, 4'd15);
    run_phase(50);
    set_atlas(9'd0, 9'd20, 4'd1);
    run_phase(8);
    set_atlas(9'd16, 9'd0, 4'd2);
    run_phase(8);
    set_atlas(9'd16, 9'd12, 4'd1);
    run_phase(90);

    // No idling; receiver holds off while the sender keeps offering
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_atlas(9'd48, 9'd40, 4'd2);
    hold_off_go = 1'b1;
    run_phase(6);
    wait_drain();
    run_phase(110);
    set_atlas(9'd256, 9'd256, 4'd0);
    run_phase(20);
    set_atlas(9'd24, 9'd24, 4'd0);
    run_phase(170);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/affrp_pkg.sv
design/affrp_shift.sv
design/atlas_first_fit_rect_placer.sv
tb/sv/testbench.sv
